// File: rtl/qcr_pkg.sv
// shared types, constants and helper functions for the quaternion compose unit
`default_nettype none

package qcr_pkg;

    // widths of the datapath
    localparam int COMP_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W = 35;
    localparam int RAD_W = 29;
    localparam int ROOT_W = 15;
    localparam int CNT_W = 8;

    // square root runs two radicand bits per cycle
    localparam int ROOT_ITERS = 15;

    // reset value of the renormalization interval
    localparam logic [CNT_W-1:0] RENORM_RESET = 8'd100;

    // component selectors
    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    // one input beat
    typedef struct packed {
        logic signed [COMP_W-1:0] first_x;
        logic signed [COMP_W-1:0] first_y;
        logic signed [COMP_W-1:0] first_z;
        logic signed [COMP_W-1:0] first_w;
        logic signed [COMP_W-1:0] second_x;
        logic signed [COMP_W-1:0] second_y;
        logic signed [COMP_W-1:0] second_z;
        logic signed [COMP_W-1:0] second_w;
    } in_t;

    // one result beat
    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     renormalized;
    } out_t;

    // one product term: first operand index, second operand index, subtract
    typedef struct packed {
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic       neg;
    } term_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic neg;
        logic add_en;
        logic clr;
    } mac_ctrl_t;

    // product schedule: four terms per output component, x, y, z, w in turn
    function automatic term_t term_lookup(input logic [3:0] step);
        term_t t;
        case (step)
            4'd0:  t = '{a_idx: IDX_X, b_idx: IDX_W, neg: 1'b0};
            4'd1:  t = '{a_idx: IDX_W, b_idx: IDX_X, neg: 1'b0};
            4'd2:  t = '{a_idx: IDX_Z, b_idx: IDX_Y, neg: 1'b0};
            4'd3:  t = '{a_idx: IDX_Y, b_idx: IDX_Z, neg: 1'b1};
            4'd4:  t = '{a_idx: IDX_Y, b_idx: IDX_W, neg: 1'b0};
            4'd5:  t = '{a_idx: IDX_W, b_idx: IDX_Y, neg: 1'b0};
            4'd6:  t = '{a_idx: IDX_X, b_idx: IDX_Z, neg: 1'b0};
            4'd7:  t = '{a_idx: IDX_Z, b_idx: IDX_X, neg: 1'b1};
            4'd8:  t = '{a_idx: IDX_Z, b_idx: IDX_W, neg: 1'b0};
            4'd9:  t = '{a_idx: IDX_W, b_idx: IDX_Z, neg: 1'b0};
            4'd10: t = '{a_idx: IDX_Y, b_idx: IDX_X, neg: 1'b0};
            4'd11: t = '{a_idx: IDX_X, b_idx: IDX_Y, neg: 1'b1};
            4'd12: t = '{a_idx: IDX_W, b_idx: IDX_W, neg: 1'b0};
            4'd13: t = '{a_idx: IDX_X, b_idx: IDX_X, neg: 1'b1};
            4'd14: t = '{a_idx: IDX_Y, b_idx: IDX_Y, neg: 1'b1};
            4'd15: t = '{a_idx: IDX_Z, b_idx: IDX_Z, neg: 1'b1};
            default: t = '{a_idx: IDX_X, b_idx: IDX_X, neg: 1'b0};
        endcase
        return t;
    endfunction

    // round half up from Q7.28 to Q2.14 and saturate to 16 bits
    function automatic logic signed [COMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-15:0] r;
        logic signed [COMP_W-1:0] q;
        t = s + 35'sd8192;
        r = $signed(t[ACC_W-1:14]);
        if (r > 21'sd32767) begin
            q = 16'sh7fff;
        end else if (r < -21'sd32768) begin
            q = 16'sh8000;
        end else begin
            q = r[COMP_W-1:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/qcr_mac.sv
// shared 16x16 signed multiplier with product register and accumulator
`default_nettype none

module qcr_mac (
    input  wire logic                                 aclk,
    input  wire logic signed [qcr_pkg::COMP_W-1:0]    op_a,
    input  wire logic signed [qcr_pkg::COMP_W-1:0]    op_b,
    input  wire qcr_pkg::mac_ctrl_t                   ctrl,
    output logic signed [qcr_pkg::ACC_W-1:0]          sum_o
);

    logic signed [qcr_pkg::PROD_W-1:0] prod_reg;
    logic                              neg_reg;
    logic signed [qcr_pkg::ACC_W-1:0]  acc_reg;
    logic signed [qcr_pkg::ACC_W-1:0]  acc_next;
    logic signed [qcr_pkg::ACC_W-1:0]  prod_ext;
    logic signed [qcr_pkg::ACC_W-1:0]  addend;

    // product stage
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
            neg_reg  <= ctrl.neg;
        end
    end

    // signed accumulate of the registered product
    always_comb begin
        prod_ext = {{(qcr_pkg::ACC_W-qcr_pkg::PROD_W){prod_reg[qcr_pkg::PROD_W-1]}}, prod_reg};
        if (!ctrl.add_en) begin
            addend = '0;
        end else if (neg_reg) begin
            addend = -prod_ext;
        end else begin
            addend = prod_ext;
        end
        sum_o    = acc_reg + addend;
        acc_next = ctrl.clr ? '0 : sum_o;
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

// File: rtl/qcr_sqrt.sv
// iterative floor square root, two radicand bits per cycle
`default_nettype none

module qcr_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [qcr_pkg::RAD_W-1:0]     rad_i,
    output logic                               done_o,
    output logic [qcr_pkg::ROOT_W-1:0]         root_o
);

    localparam int VAL_W = 2 * qcr_pkg::ROOT_W;
    localparam int REM_W = qcr_pkg::ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam logic [3:0] LAST_ITER = 4'(qcr_pkg::ROOT_ITERS - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [3:0]                    cnt_reg;
    logic [VAL_W-1:0]              val_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [qcr_pkg::ROOT_W-1:0]    root_reg;

    logic [SH_W-1:0]               rem_sh;
    logic [SH_W-1:0]               trial;
    logic                          ge;
    logic [SH_W-1:0]               rem_new;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, val_reg[VAL_W-1:VAL_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
        rem_new = ge ? (rem_sh - trial) : rem_sh;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST_ITER) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= {{(VAL_W-qcr_pkg::RAD_W){1'b0}}, rad_i};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[VAL_W-3:0], 2'b00};
            rem_reg  <= rem_new[REM_W-1:0];
            root_reg <= {root_reg[qcr_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done_o = done_reg;
    assign root_o = root_reg;

endmodule

`default_nettype wire

// File: rtl/quaternion_compose_renormalize_unit.sv
// top level: sequencer, operand selection, renormalization and handshakes
//
// Composes two Q2.14 quaternions with one shared 16x16 multiplier. After an
// input beat is accepted the sixteen products run through the multiplier one
// per cycle and the result is then offered. When the call counter passes the
// configured interval the largest component is rebuilt from the other three:
// the four squares go through the same multiplier, the three beside the
// largest are summed, and a two-bit-per-cycle root unit adds 15 iterations.
// s_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next item is already being worked on.
// cfg_ready is always high; write the interval only while the block is idle.
`default_nettype none

module quaternion_compose_renormalize_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire qcr_pkg::in_t        s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output qcr_pkg::out_t            m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_RAD  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [4:0] MUL_LAST = 5'd16;
    localparam logic [4:0] SQ_LAST  = 5'd4;
    localparam logic signed [qcr_pkg::ACC_W-1:0] ONE_SQ = 35'sd268435456;

    logic [2:0]                        state_reg, state_next;
    logic [4:0]                        step_reg, step_next;
    logic [4:0]                        step_m1;
    logic [qcr_pkg::CNT_W-1:0]         interval_reg;
    logic [qcr_pkg::CNT_W-1:0]         cnt_reg;
    logic [qcr_pkg::CNT_W:0]           cnt_inc;
    logic                              renorm_next;
    logic                              renorm_reg;
    qcr_pkg::in_t                      in_reg;
    logic signed [qcr_pkg::COMP_W-1:0] q_reg [4];
    logic [1:0]                        sel_reg;
    logic                              sel_neg_reg;
    logic                              m_valid_reg;
    qcr_pkg::out_t                     out_reg;

    logic                              accept;
    logic                              out_load;
    qcr_pkg::term_t                    term;
    qcr_pkg::mac_ctrl_t                mac_ctrl;
    logic signed [qcr_pkg::COMP_W-1:0] op_a, op_b;
    logic signed [qcr_pkg::ACC_W-1:0]  mac_sum;
    logic                              q_we;
    logic [1:0]                        q_widx;
    logic signed [qcr_pkg::COMP_W-1:0] q_wdata;
    logic [1:0]                        sel_pick;
    logic [qcr_pkg::COMP_W:0]          mag [4];
    logic [qcr_pkg::COMP_W:0]          best_mag;
    logic signed [qcr_pkg::ACC_W-1:0]  rad_diff;
    logic [qcr_pkg::RAD_W-1:0]         rad;
    logic                              sqrt_start;
    logic                              sqrt_done;
    logic [qcr_pkg::ROOT_W-1:0]        sqrt_root;
    logic signed [qcr_pkg::COMP_W-1:0] root_s;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign step_m1   = step_reg - 5'd1;
    assign term      = qcr_pkg::term_lookup(step_reg[3:0]);

    // call counter compare
    assign cnt_inc     = {1'b0, cnt_reg} + 9'd1;
    assign renorm_next = (cnt_inc > {1'b0, interval_reg});

    // largest magnitude, lowest index wins a tie
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = q_reg[i][qcr_pkg::COMP_W-1]
                ? (~{q_reg[i][qcr_pkg::COMP_W-1], q_reg[i]} + 17'd1)
                : {1'b0, q_reg[i]};
        end
        best_mag = mag[0];
        sel_pick = qcr_pkg::IDX_X;
        for (int i = 1; i < 4; i++) begin
            if (mag[i] > best_mag) begin
                best_mag = mag[i];
                sel_pick = 2'(i);
            end
        end
    end

    // radicand, clamped at zero
    always_comb begin
        rad_diff = ONE_SQ - mac_sum;
        rad      = rad_diff[qcr_pkg::ACC_W-1] ? '0 : rad_diff[qcr_pkg::RAD_W-1:0];
    end

    assign root_s = {1'b0, sqrt_root};

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        mac_ctrl   = '0;
        op_a       = '0;
        op_b       = '0;
        q_we       = 1'b0;
        q_widx     = step_m1[3:2];
        q_wdata    = qcr_pkg::round_sat(mac_sum);
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                mac_ctrl.clr = 1'b1;
                step_next    = '0;
                if (s_valid) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (!step_reg[4]) begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.neg    = term.neg;
                    case (term.a_idx)
                        qcr_pkg::IDX_X: op_a = in_reg.first_x;
                        qcr_pkg::IDX_Y: op_a = in_reg.first_y;
                        qcr_pkg::IDX_Z: op_a = in_reg.first_z;
                        default:        op_a = in_reg.first_w;
                    endcase
                    case (term.b_idx)
                        qcr_pkg::IDX_X: op_b = in_reg.second_x;
                        qcr_pkg::IDX_Y: op_b = in_reg.second_y;
                        qcr_pkg::IDX_Z: op_b = in_reg.second_z;
                        default:        op_b = in_reg.second_w;
                    endcase
                end
                if (step_reg != '0) begin
                    mac_ctrl.add_en = 1'b1;
                    if (step_m1[1:0] == 2'd3) begin
                        q_we         = 1'b1;
                        mac_ctrl.clr = 1'b1;
                    end
                end
                step_next = step_reg + 5'd1;
                if (step_reg == MUL_LAST) begin
                    step_next  = '0;
                    state_next = renorm_reg ? S_SEL : S_DONE;
                end
            end
            S_SEL: begin
                step_next  = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                if (!step_reg[2]) begin
                    mac_ctrl.mul_en = 1'b1;
                    op_a            = q_reg[step_reg[1:0]];
                    op_b            = op_a;
                end
                if (step_reg != '0 && step_m1[1:0] != sel_reg) begin
                    mac_ctrl.add_en = 1'b1;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == SQ_LAST) begin
                    state_next = S_RAD;
                end
            end
            S_RAD: begin
                sqrt_start   = 1'b1;
                mac_ctrl.clr = 1'b1;
                state_next   = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    q_we       = 1'b1;
                    q_widx     = sel_reg;
                    q_wdata    = sel_neg_reg ? -root_s : root_s;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            interval_reg <= qcr_pkg::RENORM_RESET;
            cnt_reg      <= '0;
            renorm_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready) begin
                interval_reg <= cfg_data;
            end
            if (accept) begin
                renorm_reg <= renorm_next;
                cnt_reg    <= renorm_next ? '0 : cnt_inc[qcr_pkg::CNT_W-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (q_we) begin
            q_reg[q_widx] <= q_wdata;
        end
        if (state_reg == S_SEL) begin
            sel_reg     <= sel_pick;
            sel_neg_reg <= q_reg[sel_pick][qcr_pkg::COMP_W-1];
        end
        if (out_load) begin
            out_reg.out_x        <= q_reg[0];
            out_reg.out_y        <= q_reg[1];
            out_reg.out_z        <= q_reg[2];
            out_reg.out_w        <= q_reg[3];
            out_reg.renormalized <= renorm_reg;
        end
    end

    qcr_mac u_mac (
        .aclk  (aclk),
        .op_a  (op_a),
        .op_b  (op_b),
        .ctrl  (mac_ctrl),
        .sum_o (mac_sum)
    );

    qcr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad_i   (rad),
        .done_o  (sqrt_done),
        .root_o  (sqrt_root)
    );

    // one item at a time
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a composition is in flight");

    // counter restarts whenever the item is flagged for renormalization
    a_cnt_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && renorm_next) |=> (cnt_reg == '0 && renorm_reg))
        else $error("call counter not cleared on renormalization");

    // root completes only while waiting for it, and never above one
    a_root_done : assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == S_SQRT && sqrt_root <= 15'd16384))
        else $error("unexpected square root completion");

endmodule

`default_nettype wire
